FILE: rtl/core/imdrs_pkg.sv
`timescale 1ns / 1ps

package imdrs_pkg;

  // default operand width
  localparam int unsigned DataWidthDefault = 32;

  // operation codes
  typedef enum logic [1:0] {
    CmdMul  = 2'd0,
    CmdDiv  = 2'd1,
    CmdRem  = 2'd2,
    CmdSqrt = 2'd3
  } cmd_e;

  // error codes
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrDivZero = 2'd1,
    ErrNeg     = 2'd2,
    ErrUnused  = 2'd3
  } err_e;

endpackage

FILE: rtl/core/imdrs_step.sv
`timescale 1ns / 1ps

// one iteration of the shared add/subtract unit:
// multiply: msb-first shift-add, divide: restoring step, root: digit-pair step
module imdrs_step
  import imdrs_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  cmd_e                  op_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0] x_i,
  input  logic [DATA_WIDTH-1:0] y_i,
  output logic [DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0] x_o,
  output logic [DATA_WIDTH-1:0] y_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic [W+1:0] opnd1;
  logic [W+1:0] opnd2;
  logic         sub;
  logic [W+1:0] sum;
  logic         ge;

  // operand selection for the shared adder
  always_comb begin
    opnd1 = '0;
    opnd2 = '0;
    sub   = 1'b0;
    unique case (op_i) inside
      CmdMul: begin
        opnd1 = {2'b00, acc_i[W-2:0], 1'b0};
        opnd2 = x_i[W-1] ? {2'b00, y_i} : '0;
        sub   = 1'b0;
      end
      CmdDiv, CmdRem: begin
        opnd1 = {1'b0, acc_i, x_i[W-1]};
        opnd2 = {2'b00, y_i};
        sub   = 1'b1;
      end
      default: begin
        // remainder and root stay far below the word, so the top bits are zero
        opnd1 = {acc_i, x_i[W-1:W-2]};
        opnd2 = {y_i, 2'b01};
        sub   = 1'b1;
      end
    endcase
  end

  // shared adder / subtractor
  assign sum = sub ? (opnd1 - opnd2) : (opnd1 + opnd2);
  assign ge  = ~sum[W+1];

  // next register values
  always_comb begin
    acc_o = acc_i;
    x_o   = x_i;
    y_o   = y_i;
    unique case (op_i) inside
      CmdMul: begin
        acc_o = sum[W-1:0];
        x_o   = {x_i[W-2:0], 1'b0};
      end
      CmdDiv, CmdRem: begin
        acc_o = ge ? sum[W-1:0] : opnd1[W-1:0];
        x_o   = {x_i[W-2:0], ge};
      end
      default: begin
        acc_o = ge ? sum[W-1:0] : opnd1[W-1:0];
        x_o   = {x_i[W-3:0], 2'b00};
        y_o   = {y_i[W-2:0], ge};
      end
    endcase
  end

endmodule

FILE: rtl/core/integer_mul_div_rem_sqrt.sv
`timescale 1ns / 1ps

// channel    direction  handshake           payload
// command    in         start && !busy      command_i, operand_a_i, operand_b_i
// result     out        done_o (one cycle)  result_o, error_code_o
//
// multiply, divide and remainder process one bit per cycle, square root one
// digit pair per cycle, through the single shared add/subtract unit. operand
// errors skip the loop and go straight to the done_o cycle. busy rises after
// accept and stays high through the done_o cycle.
// reset returns the sequencer to idle; the receiver cannot stall results.
module integer_mul_div_rem_sqrt
  import imdrs_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic [1:0]                   error_code_o
);

  localparam int unsigned W       = DATA_WIDTH;
  localparam int unsigned SqIter  = DATA_WIDTH / 2;
  localparam int unsigned SqShift = DATA_WIDTH - 2 * SqIter;
  localparam int unsigned CntW    = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  err_e            err_q, err_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    x_q, x_d;
  logic [W-1:0]    y_q, y_d;
  logic [W-1:0]    acc_step, x_step, y_step;
  logic            accept;
  cmd_e            cmd_in;
  err_e            err_in;

  assign accept = start && (state_q == StIdle);
  assign cmd_in = cmd_e'(command_i);

  // operand checks at accept
  always_comb begin
    err_in = ErrNone;
    case (cmd_in) inside
      CmdDiv, CmdRem: begin
        if (operand_b_i == '0) begin
          err_in = ErrDivZero;
        end else if (operand_a_i[W-1] || operand_b_i[W-1]) begin
          err_in = ErrNeg;
        end
      end
      CmdSqrt: begin
        if (operand_a_i[W-1]) begin
          err_in = ErrNeg;
        end
      end
      default: err_in = ErrNone;
    endcase
  end

  // shared iteration unit
  imdrs_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .op_i (cmd_q),
    .acc_i(acc_q),
    .x_i  (x_q),
    .y_i  (y_q),
    .acc_o(acc_step),
    .x_o  (x_step),
    .y_o  (y_step)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_d = cmd_in;
          err_d = err_in;
          acc_d = '0;
          if (cmd_in == CmdSqrt) begin
            x_d   = operand_a_i << SqShift;
            y_d   = '0;
            cnt_d = CntW'(SqIter - 1);
          end else begin
            x_d   = operand_a_i;
            y_d   = operand_b_i;
            cnt_d = CntW'(W - 1);
          end
          state_d = (err_in == ErrNone) ? StRun : StDone;
        end
      end
      StRun: begin
        acc_d = acc_step;
        x_d   = x_step;
        y_d   = y_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmd_q   <= CmdMul;
      err_q   <= ErrNone;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  // result selection
  always_comb begin
    result_o = '0;
    if (err_q == ErrNone) begin
      case (cmd_q) inside
        CmdMul, CmdRem: result_o = acc_q;
        CmdDiv:         result_o = x_q;
        default:        result_o = y_q;
      endcase
    end
  end

  assign busy         = (state_q != StIdle);
  assign done_o       = (state_q == StDone);
  assign error_code_o = err_q;

endmodule
